// ----- hdl/rrsf_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rrsf_pkg
// Shared types and constants for the ring relay sequence filter.
// ============================================================================
package rrsf_pkg;

    // Default ring size and the fixed datagram limits
    localparam int MAX_CLIENTS_DEF = 16;
    localparam int MAX_PACKET      = 1024;

    localparam int IP_W    = 32;
    localparam int PORT_W  = 16;
    localparam int SEQ_W   = 16;
    localparam int KEY_W   = IP_W + PORT_W;
    localparam int LEN_W   = 11;
    localparam int PLEN_W  = 10;
    localparam int CCNT_W  = 5;
    localparam int OIDX_W  = 4;
    localparam int HDR_LEN = 2;

    // Result codes
    typedef enum logic [2:0] {
        ACT_REGISTERED = 3'd0,
        ACT_IGNORED    = 3'd1,
        ACT_FORWARDED  = 3'd2,
        ACT_UNKNOWN    = 3'd3,
        ACT_STALE      = 3'd4,
        ACT_SHORT      = 3'd5
    } t_action;

    // Control sequencer
    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    // Write strobes broadcast to every cell
    typedef struct packed {
        logic reg_we;   // store key at the registration slot, clear sequence
        logic fwd_we;   // first matching cell takes the new sequence
    } t_cell_cmd;

    // Data handed from one cell to the next
    typedef struct packed {
        logic             hit;         // some earlier cell matched
        logic             first_here;  // this cell is the first match
        logic [SEQ_W-1:0] seq;         // stored sequence of the first match
        logic [KEY_W-1:0] daddr;       // address of the cell after the match
        logic [KEY_W-1:0] head;        // address of slot 0, for the ring wrap
    } t_link;

endpackage

// ----- hdl/ring_relay_sequence_filter_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ring_relay_sequence_filter_top
// Registers ring members, then filters and forwards datagrams around the ring.
// ============================================================================
// One datagram descriptor is handled at a time. The transaction is captured
// first; then the key ripples through the row of MAX_CLIENTS slot cells,
// the first matching slot is resolved, its sequence is checked and updated
// and the result is loaded into the output register. The output register
// lets the next transaction enter while a result waits; when the output is
// stalled the lookup holds until the register frees. client_count is written
// through i_cfg_wr_en/i_cfg_wr_data; the user must write it only while no
// transaction is in flight, as the block does not enforce this. Values of 0
// act as 1 and values above MAX_CLIENTS act as MAX_CLIENTS. Slot contents are
// undefined until registered; only registered slots are ever compared.
// ============================================================================
module ring_relay_sequence_filter_top #(
    parameter int MAX_CLIENTS = rrsf_pkg::MAX_CLIENTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [rrsf_pkg::CCNT_W-1:0]   i_cfg_wr_data,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_is_register,
    input  logic [rrsf_pkg::IP_W-1:0]     i_src_ip,
    input  logic [rrsf_pkg::PORT_W-1:0]   i_src_port,
    input  logic [rrsf_pkg::SEQ_W-1:0]    i_seq_num,
    input  logic [rrsf_pkg::LEN_W-1:0]    i_packet_len,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [2:0]                    o_action,
    output logic [rrsf_pkg::OIDX_W-1:0]   o_client_index,
    output logic [rrsf_pkg::OIDX_W-1:0]   o_dest_index,
    output logic [rrsf_pkg::IP_W-1:0]     o_dest_ip,
    output logic [rrsf_pkg::PORT_W-1:0]   o_dest_port,
    output logic [rrsf_pkg::PLEN_W-1:0]   o_payload_len
);
    import rrsf_pkg::*;

    localparam int SLOT_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_CLIENTS + 1);
    localparam int CMP_W  = (CNT_W > CCNT_W) ? CNT_W : CCNT_W;

    // Control registers
    t_state              r_state, n_state;
    logic [CCNT_W-1:0]   r_client_count;
    logic [CNT_W-1:0]    r_reg_cnt, n_reg_cnt;
    logic                r_out_valid, n_out_valid;

    // Captured transaction
    logic                r_is_reg;
    logic [KEY_W-1:0]    r_key;
    logic [SEQ_W-1:0]    r_seq;
    logic [LEN_W-1:0]    r_len;

    // Result register
    t_action             r_action, n_action;
    logic [OIDX_W-1:0]   r_cidx, n_cidx;
    logic [OIDX_W-1:0]   r_didx, n_didx;
    logic [KEY_W-1:0]    r_daddr, n_daddr;
    logic [PLEN_W-1:0]   r_plen, n_plen;

    // Cell chain
    t_link               w_link [0:MAX_CLIENTS];
    logic [SLOT_W-1:0]   w_idx  [0:MAX_CLIENTS];
    t_cell_cmd           w_cmd;

    logic [CMP_W-1:0]    w_cc_ext;
    logic [CNT_W-1:0]    w_n;
    logic [LEN_W-1:0]    w_len;
    logic                w_reg_phase;
    logic                w_out_free;
    logic                w_wrap;
    logic [SLOT_W-1:0]   w_slot;
    logic [CNT_W-1:0]    w_slot_ext;
    logic [KEY_W-1:0]    w_dest_addr;

    // Effective ring size: client_count clamped to 1..MAX_CLIENTS
    always_comb begin
        w_cc_ext = CMP_W'(r_client_count);
        if (w_cc_ext == '0) begin
            w_n = CNT_W'(1);
        end else if (w_cc_ext > CMP_W'(MAX_CLIENTS)) begin
            w_n = CNT_W'(MAX_CLIENTS);
        end else begin
            w_n = CNT_W'(w_cc_ext);
        end
    end

    // Oversize lengths clamp to the datagram limit
    assign w_len = (int'(r_len) > MAX_PACKET) ? LEN_W'(MAX_PACKET) : r_len;

    assign w_reg_phase = (r_reg_cnt < w_n);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Row of slot cells
    assign w_link[0] = '0;
    assign w_idx[0]  = '0;

    for (genvar g = 0; g < MAX_CLIENTS; g++) begin : g_cell
        rrsf_cell #(
            .MAX_CLIENTS (MAX_CLIENTS),
            .IDX         (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (w_cmd),
            .i_reg_slot (r_reg_cnt[SLOT_W-1:0]),
            .i_n        (w_n),
            .i_key      (r_key),
            .i_seq      (r_seq),
            .i_link     (w_link[g]),
            .i_idx      (w_idx[g]),
            .o_link     (w_link[g+1]),
            .o_idx      (w_idx[g+1])
        );
    end

    // Ring successor of the matched slot
    assign w_slot      = w_idx[MAX_CLIENTS];
    assign w_slot_ext  = CNT_W'(w_slot);
    assign w_wrap      = ((w_slot_ext + CNT_W'(1)) == w_n);
    assign w_dest_addr = w_wrap ? w_link[MAX_CLIENTS].head : w_link[MAX_CLIENTS].daddr;

    // Sequencer: decide the action, update the cells, load the result
    always_comb begin
        n_state     = r_state;
        n_reg_cnt   = r_reg_cnt;
        n_out_valid = r_out_valid;
        n_action    = r_action;
        n_cidx      = r_cidx;
        n_didx      = r_didx;
        n_daddr     = r_daddr;
        n_plen      = r_plen;
        w_cmd       = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (w_out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_cidx      = '0;
                    n_didx      = '0;
                    n_daddr     = '0;
                    n_plen      = '0;
                    if (w_reg_phase) begin
                        if (r_is_reg) begin
                            n_action     = ACT_REGISTERED;
                            n_cidx       = OIDX_W'(r_reg_cnt);
                            n_reg_cnt    = r_reg_cnt + CNT_W'(1);
                            w_cmd.reg_we = 1'b1;
                        end else begin
                            n_action     = ACT_IGNORED;
                        end
                    end else if (!w_link[MAX_CLIENTS].hit) begin
                        n_action = ACT_UNKNOWN;
                    end else if (w_len < LEN_W'(HDR_LEN)) begin
                        n_action = ACT_SHORT;
                        n_cidx   = OIDX_W'(w_slot);
                    end else if (r_seq <= w_link[MAX_CLIENTS].seq) begin
                        n_action = ACT_STALE;
                        n_cidx   = OIDX_W'(w_slot);
                    end else begin
                        n_action     = ACT_FORWARDED;
                        n_cidx       = OIDX_W'(w_slot);
                        n_didx       = w_wrap ? '0 : OIDX_W'(w_slot_ext + CNT_W'(1));
                        n_daddr      = w_dest_addr;
                        n_plen       = PLEN_W'(w_len - LEN_W'(HDR_LEN));
                        w_cmd.fwd_we = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_reg_cnt      <= '0;
            r_out_valid    <= 1'b0;
            r_client_count <= CCNT_W'(1);
        end else begin
            r_state     <= n_state;
            r_reg_cnt   <= n_reg_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_client_count <= i_cfg_wr_data;
            end
        end
    end

    // Transaction capture and result payload
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_in_valid) begin
            r_is_reg <= i_is_register;
            r_key    <= {i_src_ip, i_src_port};
            r_seq    <= i_seq_num;
            r_len    <= i_packet_len;
        end
        r_action <= n_action;
        r_cidx   <= n_cidx;
        r_didx   <= n_didx;
        r_daddr  <= n_daddr;
        r_plen   <= n_plen;
    end

    // Ports
    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_action       = r_action;
    assign o_client_index = r_cidx;
    assign o_dest_index   = r_didx;
    assign o_dest_ip      = r_daddr[KEY_W-1:PORT_W];
    assign o_dest_port    = r_daddr[PORT_W-1:0];
    assign o_payload_len  = r_plen;

endmodule

// ----- hdl/rrsf_cell.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rrsf_cell
// One ring slot: holds the member address and last sequence, matches the
// broadcast key and passes the first-match result on to its neighbor.
// ============================================================================
module rrsf_cell #(
    parameter int MAX_CLIENTS = rrsf_pkg::MAX_CLIENTS_DEF,
    parameter int IDX         = 0
) (
    input  logic                                           i_clk,
    input  rrsf_pkg::t_cell_cmd                            i_cmd,
    input  logic [((MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1)-1:0] i_reg_slot,
    input  logic [$clog2(MAX_CLIENTS + 1)-1:0]             i_n,
    input  logic [rrsf_pkg::KEY_W-1:0]                     i_key,
    input  logic [rrsf_pkg::SEQ_W-1:0]                     i_seq,
    input  rrsf_pkg::t_link                                i_link,
    input  logic [((MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1)-1:0] i_idx,
    output rrsf_pkg::t_link                                o_link,
    output logic [((MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1)-1:0] o_idx
);
    import rrsf_pkg::*;

    localparam int SLOT_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_CLIENTS + 1);

    logic [KEY_W-1:0] r_addr;
    logic [SEQ_W-1:0] r_seq;
    logic             w_active;
    logic             w_match;
    logic             w_first;

    // Match against the broadcast key, only for slots inside the ring
    assign w_active = (CNT_W'(IDX) < i_n);
    assign w_match  = w_active && (r_addr == i_key);
    assign w_first  = w_match && !i_link.hit;

    // Hand the first-match result along the chain
    always_comb begin
        o_link.hit        = i_link.hit | w_match;
        o_link.first_here = w_first;
        o_link.seq        = w_first ? r_seq : i_link.seq;
        o_link.daddr      = i_link.first_here ? r_addr : i_link.daddr;
        o_link.head       = (IDX == 0) ? r_addr : i_link.head;
        o_idx             = w_first ? SLOT_W'(IDX) : i_idx;
    end

    // Slot storage: registration writes the key, forwarding the sequence
    always_ff @(posedge i_clk) begin
        if (i_cmd.reg_we && (i_reg_slot == SLOT_W'(IDX))) begin
            r_addr <= i_key;
            r_seq  <= '0;
        end else if (i_cmd.fwd_we && w_first) begin
            r_seq  <= i_seq;
        end
    end

endmodule

// ----- dv/ring_relay_sequence_filter_top_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ring_relay_sequence_filter_top_tb
// Self-checking testbench for the ring relay sequence filter.
// ============================================================================
// Datagram descriptors are sent through the input channel while an in-bench
// model of the ring table predicts each result. The prediction is made when
// the input transaction is accepted, queued, and compared field by field with
// the next accepted output transaction. Directed tests cover registration,
// the one-member ring, duplicate keys, the ring wrap, short and oversize
// lengths, stale sequences and the sequence ceiling. Random tests then mix
// well-formed traffic with noise over many ring sizes, with random idle gaps
// on both channels and one long output hold-off.
// ============================================================================
module ring_relay_sequence_filter_top_tb;
    import rrsf_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 12;
    localparam int MAX_GAP      = 17;
    localparam int SETTLE       = 8;
    localparam int HOLD_OFF     = 300;
    localparam int STUCK_LIMIT  = 2000;
    localparam int RAND_BLOCKS  = 19;
    localparam int BLOCK_ITEMS  = 100;

    typedef struct packed {
        logic              is_register;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
        logic [SEQ_W-1:0]  seq;
        logic [LEN_W-1:0]  len;
    } t_datagram;

    typedef struct {
        t_action            action;
        logic [OIDX_W-1:0]  client_index;
        logic [OIDX_W-1:0]  dest_index;
        logic [IP_W-1:0]    dest_ip;
        logic [PORT_W-1:0]  dest_port;
        logic [PLEN_W-1:0]  payload_len;
    } t_relay_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CCNT_W-1:0]    i_cfg_wr_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_is_register;
    logic [IP_W-1:0]      i_src_ip;
    logic [PORT_W-1:0]    i_src_port;
    logic [SEQ_W-1:0]     i_seq_num;
    logic [LEN_W-1:0]     i_packet_len;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [2:0]           o_action;
    logic [OIDX_W-1:0]    o_client_index;
    logic [OIDX_W-1:0]    o_dest_index;
    logic [IP_W-1:0]      o_dest_ip;
    logic [PORT_W-1:0]    o_dest_port;
    logic [PLEN_W-1:0]    o_payload_len;

    // Ring table model
    logic [CCNT_W-1:0]    ring_cfg;
    int                   joined_count;
    logic [KEY_W-1:0]     member_key [MAX_CLIENTS_DEF];
    logic [SEQ_W-1:0]     member_seq [MAX_CLIENTS_DEF];

    t_relay_result        expected_relays [$];
    int                   error_count;
    int                   datagrams_sent;
    int                   ring_writes;
    int                   action_seen [0:5];
    bit                   tx_idle;
    bit                   rx_idle;
    int                   rx_hold_request;

    ring_relay_sequence_filter_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_is_register  (i_is_register),
        .i_src_ip       (i_src_ip),
        .i_src_port     (i_src_port),
        .i_seq_num      (i_seq_num),
        .i_packet_len   (i_packet_len),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_action       (o_action),
        .o_client_index (o_client_index),
        .o_dest_index   (o_dest_index),
        .o_dest_ip      (o_dest_ip),
        .o_dest_port    (o_dest_port),
        .o_payload_len  (o_payload_len)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Effective ring size: 0 acts as 1, anything above the table size saturates
    function automatic int ring_members();
        if (ring_cfg == '0) return 1;
        if (ring_cfg > MAX_CLIENTS_DEF) return MAX_CLIENTS_DEF;
        return int'(ring_cfg);
    endfunction

    // Predict the result of one datagram and update the ring table model
    function automatic t_relay_result predict_relay(input t_datagram d);
        t_relay_result    r;
        logic [KEY_W-1:0] key;
        int               eff_len;
        int               members;
        int               slot;
        int               nxt;
        r.action       = ACT_IGNORED;
        r.client_index = '0;
        r.dest_index   = '0;
        r.dest_ip      = '0;
        r.dest_port    = '0;
        r.payload_len  = '0;
        key     = {d.ip, d.port};
        eff_len = (d.len > MAX_PACKET) ? MAX_PACKET : int'(d.len);
        members = ring_members();

        // registration phase: only register messages take a slot
        if (joined_count < members) begin
            if (d.is_register) begin
                member_key[joined_count] = key;
                member_seq[joined_count] = '0;
                r.action       = ACT_REGISTERED;
                r.client_index = OIDX_W'(joined_count);
                joined_count++;
            end
            return r;
        end

        // lowest matching slot wins
        slot = -1;
        for (int i = 0; i < members; i++) begin
            if (slot < 0 && member_key[i] == key) slot = i;
        end
        if (slot < 0) begin
            r.action = ACT_UNKNOWN;
            return r;
        end
        r.client_index = OIDX_W'(slot);
        if (eff_len < HDR_LEN) begin
            r.action = ACT_SHORT;
        end else if (d.seq <= member_seq[slot]) begin
            r.action = ACT_STALE;
        end else begin
            member_seq[slot] = d.seq;
            nxt = (slot + 1 >= members) ? 0 : slot + 1;
            r.action      = ACT_FORWARDED;
            r.dest_index  = OIDX_W'(nxt);
            r.dest_ip     = member_key[nxt][KEY_W-1:PORT_W];
            r.dest_port   = member_key[nxt][PORT_W-1:0];
            r.payload_len = PLEN_W'(eff_len - HDR_LEN);
        end
        return r;
    endfunction

    // Offer one datagram; valid stays high after acceptance until the next
    // gap or a drain lowers it
    task automatic send_datagram(input logic is_reg, input logic [IP_W-1:0] ip,
                                 input logic [PORT_W-1:0] port,
                                 input logic [SEQ_W-1:0] seq,
                                 input logic [LEN_W-1:0] len);
        t_datagram d;
        int        gap;
        d   = '{is_register: is_reg, ip: ip, port: port, seq: seq, len: len};
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_is_register <= d.is_register;
        i_src_ip      <= d.ip;
        i_src_port    <= d.port;
        i_seq_num     <= d.seq;
        i_packet_len  <= d.len;
        forever begin
            @(posedge i_clk);
            if (o_in_stall === 1'b0) break;
        end
        expected_relays.push_back(predict_relay(d));
        datagrams_sent++;
    endtask

    // Sender pause: wait for every outstanding result, then let the block settle
    task automatic wait_relays_drained();
        i_in_valid <= 1'b0;
        while (expected_relays.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Ring size register write, only with nothing in flight
    task automatic write_ring_size(input logic [CCNT_W-1:0] value);
        wait_relays_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        ring_cfg = value;
        ring_writes++;
        @(posedge i_clk);
    endtask

    // Random datagram, mostly from ring members with a plausible sequence
    function automatic t_datagram random_datagram();
        t_datagram d;
        int        pick;
        int        slot;
        int        last;
        int        s;
        pick = $urandom_range(0, 99);
        slot = (pick < 12) ? $urandom_range(0, MAX_CLIENTS_DEF - 1)
                           : $urandom_range(0, ring_members() - 1);
        d.is_register = 1'($urandom_range(0, 1));
        d.ip          = member_key[slot][KEY_W-1:PORT_W];
        d.port        = member_key[slot][PORT_W-1:0];
        if (pick < 8) begin
            d.ip   = $urandom();
            d.port = PORT_W'($urandom());
        end
        last = int'(member_seq[slot]);
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            s = last + $urandom_range(1, 150);
            if (s > 65535) s = 65535;
        end else if (pick < 99) begin
            s = $urandom_range(0, last);
        end else begin
            s = $urandom_range(0, 65535);
        end
        d.seq = SEQ_W'(s);
        pick  = $urandom_range(0, 99);
        if (pick < 5)       d.len = LEN_W'($urandom_range(0, 1));
        else if (pick < 10) d.len = LEN_W'($urandom_range(MAX_PACKET + 1, 2047));
        else                d.len = LEN_W'($urandom_range(HDR_LEN, MAX_PACKET));
        return d;
    endfunction

    task automatic send_random_datagram();
        t_datagram d;
        d = random_datagram();
        send_datagram(d.is_register, d.ip, d.port, d.seq, d.len);
    endtask

    // One-member ring: registration, self-forwarding, length and sequence cases
    task automatic test_single_member_ring();
        write_ring_size(5'd0);
        send_datagram(1'b0, 32'hC0A8_0001, 16'd5000, 16'd1, 11'd40);
        send_datagram(1'b1, '1, '1, 16'd0, 11'd8);
        send_datagram(1'b0, '1, '1, 16'd0, 11'd100);
        send_datagram(1'b0, '1, '1, 16'd1, 11'd2);
        send_datagram(1'b0, '1, '1, 16'd2, 11'd1);
        send_datagram(1'b0, '1, '1, 16'd2, 11'd0);
        send_datagram(1'b0, '1, 16'hFFFE, 16'd9, 11'd50);
        send_datagram(1'b0, '1, '1, 16'd3, 11'd1024);
        send_datagram(1'b0, '1, '1, 16'd4, 11'd2047);
        send_datagram(1'b1, '1, '1, 16'd5, 11'd1025);
    endtask

    // Reopen registration for two more slots, one a duplicate key
    task automatic test_three_member_ring();
        write_ring_size(5'd3);
        send_datagram(1'b0, '0, '0, 16'hFFFF, 11'd0);
        send_datagram(1'b1, '0, '0, 16'hFFFF, 11'd3);
        send_datagram(1'b1, '1, '1, 16'd7, 11'd12);
        send_datagram(1'b0, '1, '1, 16'd6, 11'd64);
        send_datagram(1'b0, '0, '0, 16'd1, 11'd64);
    endtask

    // Lowered ring size: the wrap moves and the extra slot is not compared
    task automatic test_shrunk_ring();
        write_ring_size(5'd2);
        send_datagram(1'b0, '0, '0, 16'd2, 11'd300);
        send_datagram(1'b1, $urandom(), 16'($urandom()), 16'd3, 11'd30);
    endtask

    // Saturating size fills the table with random keys amid ignored noise
    task automatic test_full_ring_registration();
        write_ring_size(5'd31);
        while (joined_count < ring_members()) begin
            send_datagram($urandom_range(0, 9) < 7, $urandom(), 16'($urandom()),
                          16'($urandom()), 11'($urandom()));
        end
    endtask

    // Highest sequence forwards once, then every value is stale
    task automatic test_sequence_ceiling();
        write_ring_size(5'd16);
        send_datagram(1'b0, member_key[15][KEY_W-1:PORT_W], member_key[15][PORT_W-1:0],
                      16'hFFFF, 11'd512);
        send_datagram(1'b0, member_key[15][KEY_W-1:PORT_W], member_key[15][PORT_W-1:0],
                      16'hFFFF, 11'd512);
    endtask

    // Long output hold-off while the sender keeps offering
    task automatic test_output_backpressure();
        write_ring_size(5'd17);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        rx_hold_request = HOLD_OFF;
        repeat (40) send_random_datagram();
        wait_relays_drained();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Random traffic over many ring sizes and idle mixes
    task automatic test_random_traffic();
        int pick;
        logic [CCNT_W-1:0] size;
        for (int b = 0; b < RAND_BLOCKS; b++) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       size = 5'd0;
                1:       size = 5'd1;
                2:       size = 5'd16;
                3:       size = 5'd31;
                4, 5:    size = CCNT_W'($urandom_range(17, 30));
                default: size = CCNT_W'($urandom_range(2, 15));
            endcase
            write_ring_size(size);
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
            repeat (BLOCK_ITEMS) send_random_datagram();
        end
    endtask

    // Output receiver: random stall per transaction, plus a requested hold-off
    initial begin
        int n;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            n = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (rx_hold_request > 0) begin
                n = rx_hold_request;
                rx_hold_request = 0;
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            forever begin
                @(posedge i_clk);
                if (o_out_valid === 1'b1) break;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_relay_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_relays.size() == 0) begin
                $error("result with no datagram pending: action %0d", o_action);
                error_count++;
            end else begin
                want = expected_relays.pop_front();
                action_seen[want.action]++;
                check_field("action", 32'(want.action), 32'(o_action));
                check_field("client_index", 32'(want.client_index), 32'(o_client_index));
                check_field("dest_index", 32'(want.dest_index), 32'(o_dest_index));
                check_field("dest_ip", want.dest_ip, o_dest_ip);
                check_field("dest_port", 32'(want.dest_port), 32'(o_dest_port));
                check_field("payload_len", 32'(want.payload_len), 32'(o_payload_len));
            end
        end
    end

    // Watchdog: cycles in a row with no transaction on either channel
    initial begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && i_out_stall === 1'b0))
                stuck = 0;
            else
                stuck++;
        end
        $display("no transaction for %0d cycles, %0d results outstanding",
                 STUCK_LIMIT, expected_relays.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Test sequence
    initial begin
        error_count     = 0;
        datagrams_sent  = 0;
        ring_writes     = 0;
        rx_hold_request = 0;
        tx_idle         = 1'b1;
        rx_idle         = 1'b1;
        ring_cfg        = 5'd1;
        joined_count    = 0;
        for (int i = 0; i < 6; i++) action_seen[i] = 0;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        i_in_valid    <= 1'b0;
        i_is_register <= 1'b0;
        i_src_ip      <= '0;
        i_src_port    <= '0;
        i_seq_num     <= '0;
        i_packet_len  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_member_ring();
        test_three_member_ring();
        test_shrunk_ring();
        test_full_ring_registration();
        test_sequence_ceiling();
        test_output_backpressure();
        test_random_traffic();
        wait_relays_drained();

        $display("Covered %0d datagrams over %0d ring size writes: %0d registered,",
                 datagrams_sent, ring_writes, action_seen[ACT_REGISTERED]);
        $display("  %0d ignored, %0d forwarded, %0d unknown, %0d stale, %0d short",
                 action_seen[ACT_IGNORED], action_seen[ACT_FORWARDED],
                 action_seen[ACT_UNKNOWN], action_seen[ACT_STALE],
                 action_seen[ACT_SHORT]);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
